>>> rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared constants, codes and types of the marker frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // frame layout
  localparam int HEADER_LEN = 2;   // header bytes, sync included (1..16)
  localparam int CRC_LEN    = 2;   // CRC bytes after the terminator (0..8)

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_SECOND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY    = 2'd3;

  // configuration reset values
  localparam logic [7:0] SYNC_RST   = 8'h61;  // 'a'
  localparam logic [7:0] TERM1_RST  = 8'h63;  // 'c'
  localparam logic [7:0] TERM2_RST  = 8'h64;  // 'd'
  localparam logic [7:0] MAXB_RST   = 8'd64;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] body_length;
    logic       last;
  } mfd_res_t;

  // results of one step, up to two words
  typedef struct packed {
    logic [1:0] n;
    mfd_res_t   r0;
    mfd_res_t   r1;
  } mfd_push_t;

endpackage

>>> rtl/mfd_core.sv
// ----------------------------------------------------------------------------
// mfd_core
// Frame state machine and configuration registers; one byte per cycle while in_fire is high.
// ----------------------------------------------------------------------------
module mfd_core import mfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_eob,
  input  logic                 cfg_fire,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output mfd_push_t            push
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEADER, PH_BODY, PH_CRC, PH_DONE
  } phase_t;

  phase_t     ph_r, ph_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] hb_r, hb_nxt;     // held byte in body, CRC count after
  logic       hv_r, hv_nxt;
  logic       rep_r, rep_nxt;

  logic [7:0] sync_r, term1_r, term2_r, maxb_r;

  logic       ea, eb, ec;
  logic [1:0] ea_kind;
  logic [7:0] ea_data;
  logic [7:0] cnt_inc;
  mfd_res_t   res_a, res_b, res_c;

  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    hb_nxt  = hb_r;
    hv_nxt  = hv_r;
    rep_nxt = rep_r;
    ea      = 1'b0;
    ea_kind = KIND_BYTE;
    ea_data = 8'd0;
    eb      = 1'b0;
    ec      = 1'b0;
    unique case (ph_r)
      PH_HUNT: begin
        if (in_byte == sync_r) begin
          if (HEADER_LEN <= 1) begin
            ph_nxt  = PH_BODY;
            cnt_nxt = 8'd0;
            hv_nxt  = 1'b0;
          end else begin
            ph_nxt  = PH_HEADER;
            cnt_nxt = 8'd1;
          end
        end
      end
      PH_HEADER: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 8'(HEADER_LEN)) begin
          ph_nxt  = PH_BODY;
          cnt_nxt = 8'd0;
          hv_nxt  = 1'b0;
        end
      end
      PH_BODY: begin
        if (hv_r && hb_r == term1_r && in_byte == term2_r) begin
          hv_nxt = 1'b0;
          hb_nxt = 8'd0;
          ph_nxt = PH_CRC;
        end else if (hv_r && ({1'b0, cnt_r} + 9'd1 >= {1'b0, maxb_r})) begin
          // body too long
          ea      = 1'b1;
          ea_kind = KIND_INVALID;
          rep_nxt = 1'b1;
          ph_nxt  = PH_DONE;
          hv_nxt  = 1'b0;
        end else begin
          if (hv_r) begin
            ea      = 1'b1;
            ea_data = hb_r;
            cnt_nxt = cnt_inc;
          end
          hb_nxt = in_byte;
          hv_nxt = 1'b1;
        end
      end
      PH_CRC:  hb_nxt = hb_r + 8'd1;
      PH_DONE: ;
      default: ;
    endcase

    if (ph_nxt == PH_CRC && hb_nxt >= 8'(CRC_LEN)) begin
      eb      = 1'b1;
      rep_nxt = 1'b1;
      ph_nxt  = PH_DONE;
      hb_nxt  = 8'd0;
    end

    if (in_eob) begin
      ec      = ~rep_nxt;
      ph_nxt  = PH_HUNT;
      cnt_nxt = 8'd0;
      hb_nxt  = 8'd0;
      hv_nxt  = 1'b0;
      rep_nxt = 1'b0;
    end
  end

  // note: accept length is the body count after this byte
  always_comb begin
    res_a = '{kind: ea_kind, data: ea_data, body_length: 8'd0, last: 1'b0};
    res_b = '{kind: KIND_ACCEPT, data: 8'd0, body_length: cnt_r, last: 1'b0};
    res_c = '{kind: KIND_INVALID, data: 8'd0, body_length: 8'd0, last: 1'b1};
    push.r1 = res_c;
    if (ea || eb) begin
      push.r0      = ea ? res_a : res_b;
      push.r0.last = ~ec;
      push.n       = ec ? 2'd2 : 2'd1;
    end else begin
      push.r0 = res_c;
      push.n  = ec ? 2'd1 : 2'd0;
    end
    if (!in_fire) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_HUNT;
      cnt_r   <= 8'd0;
      hb_r    <= 8'd0;
      hv_r    <= 1'b0;
      rep_r   <= 1'b0;
      sync_r  <= SYNC_RST;
      term1_r <= TERM1_RST;
      term2_r <= TERM2_RST;
      maxb_r  <= MAXB_RST;
    end else begin
      if (in_fire) begin
        ph_r  <= ph_nxt;
        cnt_r <= cnt_nxt;
        hb_r  <= hb_nxt;
        hv_r  <= hv_nxt;
        rep_r <= rep_nxt;
      end
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_SYNC_BYTE:   sync_r  <= cfg_data;
          REG_TERM_FIRST:  term1_r <= cfg_data;
          REG_TERM_SECOND: term2_r <= cfg_data;
          REG_MAX_BODY:    maxb_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/mfd_res_fifo.sv
// ----------------------------------------------------------------------------
// mfd_res_fifo
// Result queue: takes up to two words a cycle, gives one a cycle while rd_ready is high.
// ----------------------------------------------------------------------------
module mfd_res_fifo import mfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mfd_push_t push,
  output logic      room,     // space for a full two-word step
  output logic      rd_valid,
  input  logic      rd_ready,
  output mfd_res_t  rd_data
);

  mfd_res_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                pop;
  logic [QPTR_W-1:0]   wp_1;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];
  assign room     = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign wp_1     = wp_r + QPTR_W'(1);

  always_comb begin
    wp_nxt  = wp_r + QPTR_W'(push.n);
    rp_nxt  = pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp_r] <= push.r0;
    if (push.n == 2'd2) mem[wp_1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/marker_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// marker_frame_deframer_unit
// Byte-stream frame deframer: hunts for the sync byte, skips header,
// passes body bytes, drops the terminator and CRC, reports each frame.
// ----------------------------------------------------------------------------
// Output: the result words of a byte are registered in the result queue and offered from its head in order.
// Throughput: one byte a cycle while the four-word result queue has room for a
//   two-word step; the single-pass state step sets this. A byte causing two
//   words is buffered by the queue; in_tready drops when it lacks room.
// Reset: rst_n synchronous, active low; hunting, queue empty, registers at
//   their defaults.
module marker_frame_deframer_unit import mfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input bytes
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] in_byte
  input  logic                 in_tlast,   // end_of_buffer
  // results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [7:0] out_byte, [15:8] body_length
  output logic [1:0]           out_tuser,  // [1:0] kind
  output logic                 out_tlast,  // last word of this input byte
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  mfd_push_t push;
  mfd_res_t  head;
  logic      room;
  logic      in_fire;

  // take a byte only when the queue can hold a two-word step
  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  mfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_eob    (in_tlast),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  mfd_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {head.body_length, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

>>> rtl/mfd_checker.sv
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module mfd_checker import mfd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // only the three defined kinds appear
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined result kind");

  // accepted frame carries no byte
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ACCEPT |-> out_tdata[7:0] == 8'd0)
    else $error("accept word with byte");

  // length only on accepted frames
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ACCEPT |-> out_tdata[15:8] == 8'd0)
    else $error("length on non-accept word");

endmodule

bind marker_frame_deframer_unit mfd_checker u_mfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
